@@ rtl/swhs_pkg.sv @@
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhs_pkg;

    // Data pulses per read, the first one being the presence pulse
    localparam int unsigned PULSE_COUNT = 41;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [15:0] START_LOW_RST = 16'd550;
    localparam logic [7:0]  ACK_START_RST = 8'd25;
    localparam logic [7:0]  ACK_END_RST   = 8'd50;
    localparam logic [7:0]  SYNC_RST      = 8'd35;
    localparam logic [7:0]  DATA_RST      = 8'd50;
    localparam logic [7:0]  THRESHOLD_RST = 8'd11;

    // Item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_START    = 3'd1,
        PH_ACK_HIGH = 3'd2,
        PH_ACK_LOW  = 3'd3,
        PH_SYNC     = 3'd4,
        PH_DATA     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_PRESENT = 3'd1,
        ST_ACK_LONG    = 3'd2,
        ST_CHECKSUM    = 3'd3,
        ST_DATA_TMO    = 3'd4,
        ST_SYNC_TMO    = 3'd5
    } status_t;

    // One input beat
    typedef struct packed {
        logic operation;
        logic pin_level;
    } item_t;

    // One result beat, packed from the highest bit down in field order
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [14:0]        humidity_tenths;
        status_t            status;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ rtl/swhs_in_stage.sv @@
// ----------------------------------------------------------------------------
// swhs_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module swhs_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swhs_pkg::item_t      in_item,
    input  logic                 take,
    output logic                 held_valid,
    output swhs_pkg::item_t      held_item
);
    import swhs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept whenever empty or the held beat leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ rtl/swhs_core.sv @@
// ----------------------------------------------------------------------------
// swhs_core
// Protocol state, configuration registers and the per-tick update that times
// the start pulse, acknowledge and data pulses and decodes the frame.
// ----------------------------------------------------------------------------
module swhs_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  swhs_pkg::item_t                      item,
    input  logic                                 cfg_we,
    input  logic [swhs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swhs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output swhs_pkg::result_t                    result
);
    import swhs_pkg::*;

    // Configuration
    logic [15:0] start_low_reg;
    logic [7:0]  ack_start_reg;
    logic [7:0]  ack_end_reg;
    logic [7:0]  sync_reg;
    logic [7:0]  data_reg;
    logic [7:0]  threshold_reg;

    // Protocol state
    phase_t             phase_reg, phase_next;
    logic [15:0]        tick_reg, tick_next;
    logic [5:0]         bit_reg, bit_next;
    logic [39:0]        shift_reg, shift_next;
    logic [14:0]        hum_reg, hum_next;
    logic signed [15:0] temp_reg, temp_next;

    logic        finish;
    status_t     finish_code;
    logic        drive;
    logic [15:0] tick_inc;
    logic        bit_val;
    logic [39:0] shift_cand;
    logic [15:0] hum_word;
    logic [15:0] tmp_word;
    logic [7:0]  byte_sum;
    logic        sum_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= START_LOW_RST;
            ack_start_reg <= ACK_START_RST;
            ack_end_reg   <= ACK_END_RST;
            sync_reg      <= SYNC_RST;
            data_reg      <= DATA_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_LOW: start_low_reg <= cfg_data;
                CFG_ACK_START: ack_start_reg <= cfg_data[7:0];
                CFG_ACK_END:   ack_end_reg   <= cfg_data[7:0];
                CFG_SYNC:      sync_reg      <= cfg_data[7:0];
                CFG_DATA:      data_reg      <= cfg_data[7:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Bit decode and frame check on the candidate shift word
    assign tick_inc   = tick_reg + 16'd1;
    assign bit_val    = (tick_inc > {8'd0, threshold_reg});
    assign shift_cand = {shift_reg[38:0], bit_val};
    assign hum_word   = shift_cand[39:24];
    assign tmp_word   = shift_cand[23:8];
    assign byte_sum   = hum_word[15:8] + hum_word[7:0] + tmp_word[15:8] + tmp_word[7:0];
    assign sum_ok     = (byte_sum == shift_cand[7:0]);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        hum_next    = hum_reg;
        temp_next   = temp_reg;
        finish      = 1'b0;
        finish_code = ST_OK;
        drive       = 1'b0;
        if (step)
        begin
            if (item.operation == OP_START)
            begin
                phase_next = PH_START;
                tick_next  = '0;
                bit_next   = '0;
                shift_next = '0;
                drive      = 1'b1;
            end
            else
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_next = tick_inc;
                end
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_START:
                    begin
                        if (tick_inc >= start_low_reg)
                        begin
                            phase_next = PH_ACK_HIGH;
                            tick_next  = '0;
                        end
                        else
                        begin
                            drive = 1'b1;
                        end
                    end
                    PH_ACK_HIGH:
                    begin
                        if (item.pin_level)
                        begin
                            phase_next = PH_ACK_LOW;
                            tick_next  = '0;
                        end
                        else if (tick_inc > {8'd0, ack_start_reg})
                        begin
                            finish      = 1'b1;
                            finish_code = ST_NOT_PRESENT;
                        end
                    end
                    PH_ACK_LOW:
                    begin
                        if (!item.pin_level)
                        begin
                            phase_next = PH_SYNC;
                            tick_next  = '0;
                        end
                        else if (tick_inc > {8'd0, ack_end_reg})
                        begin
                            finish      = 1'b1;
                            finish_code = ST_ACK_LONG;
                        end
                    end
                    PH_SYNC:
                    begin
                        if (item.pin_level)
                        begin
                            phase_next = PH_DATA;
                            tick_next  = '0;
                        end
                        else if (tick_inc > {8'd0, sync_reg})
                        begin
                            finish      = 1'b1;
                            finish_code = ST_SYNC_TMO;
                        end
                    end
                    PH_DATA:
                    begin
                        if (!item.pin_level)
                        begin
                            // drop the presence pulse, shift in the rest MSB first
                            if (bit_reg != 6'd0)
                            begin
                                shift_next = shift_cand;
                            end
                            bit_next  = bit_reg + 6'd1;
                            tick_next = '0;
                            if (bit_next >= 6'(PULSE_COUNT))
                            begin
                                finish = 1'b1;
                                if (!sum_ok)
                                begin
                                    finish_code = ST_CHECKSUM;
                                end
                                else
                                begin
                                    finish_code = ST_OK;
                                    hum_next    = hum_word[14:0];
                                    // sign-magnitude to two's complement
                                    if (tmp_word[15])
                                    begin
                                        temp_next = -$signed({1'b0, tmp_word[14:0]});
                                    end
                                    else
                                    begin
                                        temp_next = $signed(tmp_word);
                                    end
                                end
                            end
                            else
                            begin
                                phase_next = PH_SYNC;
                            end
                        end
                        else if (tick_inc > {8'd0, data_reg})
                        begin
                            finish      = 1'b1;
                            finish_code = ST_DATA_TMO;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                endcase
                if (finish)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
        end
    end

    // Result of this beat
    always_comb
    begin
        result.drive_low          = drive;
        result.busy_res           = (phase_next != PH_IDLE);
        result.done_res           = finish;
        result.status             = finish_code;
        result.humidity_tenths    = hum_next;
        result.temperature_tenths = temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            hum_reg   <= '0;
            temp_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            hum_reg   <= hum_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

@@ rtl/swhs_out_stage.sv @@
// ----------------------------------------------------------------------------
// swhs_out_stage
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module swhs_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  swhs_pkg::result_t                 result,
    output logic                              space,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swhs_pkg::OUT_W-1:0]        out_data
);
    import swhs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Room for a new beat when empty or the current one leaves now
    assign space      = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(OUT_W - RESULT_W){1'b0}}, data_reg};

endmodule

@@ rtl/single_wire_humidity_sensor_reader.sv @@
// An accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the result stream stalls; the per-tick
//   protocol state update is one combinational pass, input to result register.
// Reset (rst_n, asynchronous, active low): read idle, counters and shift word
//   cleared, last readings zero, configuration registers at their defaults.
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Times a single-wire humidity/temperature sensor transaction from pin samples
// and reports humidity and signed temperature in tenths.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [0] pin_level
    input  logic                                 s_axis_tuser,  // [0] operation
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [5:3] status,
    // [20:6] humidity_tenths, [36:21] temperature_tenths, [39:37] zero
    output logic [swhs_pkg::OUT_W-1:0]           m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [swhs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swhs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import swhs_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_space;
    logic    advance;
    result_t result;

    assign in_item.operation = s_axis_tuser;
    assign in_item.pin_level = s_axis_tdata[0];

    // Process the held beat when the result register has room
    assign advance = held_valid && out_space;

    swhs_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    swhs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (held_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    swhs_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .space     (out_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ rtl/swhs_checker.sv @@
// ----------------------------------------------------------------------------
// swhs_checker
// Port-level checks on the result stream of the sensor reader.
// ----------------------------------------------------------------------------
module swhs_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [swhs_pkg::OUT_W-1:0]           m_axis_tdata
);
    import swhs_pkg::*;

    result_t res;
    assign res = result_t'(m_axis_tdata[RESULT_W-1:0]);

    // A finished or failed read leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.done_res |-> !res.busy_res)
        else $error("done beat reports busy");

    // Only a finishing beat carries a status code
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.done_res |-> res.status == ST_OK)
        else $error("status without done");

    // Driving the line low only happens inside a read
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.drive_low |-> res.busy_res && !res.done_res)
        else $error("drive_low outside a read");

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The input stalls only behind a stalled result beat
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room at the output");

endmodule

bind single_wire_humidity_sensor_reader swhs_checker u_swhs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
